@@ rtl/grc_pkg.sv @@
// ----------------------------------------------------------------------------
// grc_pkg: shared definitions for the greedy rectangle cover
// grid size, field widths and the request structs between the submodules
// ----------------------------------------------------------------------------
package grc_pkg;

    localparam int GRID_COLUMNS = 8;
    localparam int GRID_ROWS    = 8;
    localparam int MAX_RESULTS  = 32;

    localparam int COL_W     = $clog2(GRID_COLUMNS);
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int ROW_CNT_W = $clog2(GRID_ROWS + 1);
    localparam int CNT_W     = $clog2(MAX_RESULTS + 1);

    // fixed widths of the stream fields
    localparam int CELL_W    = 3;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    typedef logic [GRID_COLUMNS-1:0] row_t;

    // write request into the occupancy bitmap: set or clear mask bits in one row
    typedef struct packed {
        logic             en;
        logic             set;
        logic [ROW_W-1:0] addr;
        row_t             mask;
    } wr_req_t;

    // result of the shared row scan unit
    typedef struct packed {
        logic             nonzero;
        logic [COL_W-1:0] first_x;
        logic [COL_W-1:0] last_x;
        row_t             run_mask;
        logic             span_full;
    } scan_res_t;

endpackage

@@ rtl/grc_bitmap.sv @@
// ----------------------------------------------------------------------------
// grc_bitmap: occupancy bitmap of the cell window
// one row read and one row write (set or clear under mask) per cycle
// ----------------------------------------------------------------------------
module grc_bitmap (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  grc_pkg::wr_req_t            wr,
    input  logic [grc_pkg::ROW_W-1:0]   rd_addr,
    output grc_pkg::row_t               rd_data,
    output logic                        occ_any
);

    grc_pkg::row_t rows_reg [grc_pkg::GRID_ROWS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < grc_pkg::GRID_ROWS; i++) begin
                rows_reg[i] <= '0;
            end
        end else if (wr.en) begin
            if (wr.set) begin
                rows_reg[wr.addr] <= rows_reg[wr.addr] | wr.mask;
            end else begin
                rows_reg[wr.addr] <= rows_reg[wr.addr] & ~wr.mask;
            end
        end
    end

    assign rd_data = rows_reg[rd_addr];

    // any cell still set anywhere
    always_comb begin
        occ_any = 1'b0;
        for (int i = 0; i < grc_pkg::GRID_ROWS; i++) begin
            occ_any = occ_any | (|rows_reg[i]);
        end
    end

endmodule

@@ rtl/grc_row_unit.sv @@
// ----------------------------------------------------------------------------
// grc_row_unit: shared row scan unit
// finds the first set cell of a row, the run of set cells from it, and
// checks whether a row fully covers a given span
// ----------------------------------------------------------------------------
module grc_row_unit (
    input  grc_pkg::row_t     row_data,
    input  grc_pkg::row_t     span_mask,
    output grc_pkg::scan_res_t res
);

    logic [grc_pkg::GRID_COLUMNS:0] ext;
    logic [grc_pkg::GRID_COLUMNS:0] low;
    logic [grc_pkg::GRID_COLUMNS:0] sum;
    grc_pkg::row_t                  run;

    always_comb begin
        ext = {1'b0, row_data};
        // isolate lowest set bit
        low = ext & (~ext + (grc_pkg::GRID_COLUMNS + 1)'(1));
        // adding it carries through the run of ones, leaving the run cleared
        sum = ext + low;
        run = row_data & ~sum[grc_pkg::GRID_COLUMNS-1:0];

        res.nonzero   = |row_data;
        res.run_mask  = run;
        res.span_full = ((row_data & span_mask) == span_mask);
        res.first_x   = '0;
        res.last_x    = '0;
        for (int i = 0; i < grc_pkg::GRID_COLUMNS; i++) begin
            if (low[i]) begin
                res.first_x = grc_pkg::COL_W'(i);
            end
            if (run[i]) begin
                res.last_x = grc_pkg::COL_W'(i);
            end
        end
    end

endmodule

@@ rtl/greedy_rectangle_cover.sv @@
// ----------------------------------------------------------------------------
// greedy_rectangle_cover: greedy rectangle cover of an 8 x 8 cell window
// loads occupied cells, then covers them with rectangles in raster order
// ----------------------------------------------------------------------------
// Cells are loaded one request per cycle on the s_ channel; a request with
// tlast high ends loading and starts the merge, during which s_tready is low.
// Each rectangle starts at the lowest remaining row and lowest column in it,
// grows right across the run of set cells, then upward while each next row
// covers the whole span; its cells are cleared as it grows. The start search
// visits one row at a time, growth adds one row at a time until a row fails
// or the top is passed, and each rectangle is then queued, which waits while
// the output register is full and stalled; the single row scan unit and the
// one bitmap row port set this pace. A rectangle is held back one step so
// that the final one can carry tlast. An empty window gives one result with
// tuser (set_empty) and tlast high and zero corners. The bitmap is clear when
// the last result is queued, and loading of the next window may start while
// that result still waits.
// ----------------------------------------------------------------------------
module greedy_rectangle_cover (
    input  logic                            aclk,
    input  logic                            aresetn,
    // cell requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [grc_pkg::S_TDATA_W-1:0]   s_tdata,  // cell_x[2:0], cell_y[5:3]
    input  logic                            s_tuser,  // cell_present
    input  logic                            s_tlast,  // last_cell
    // rectangle results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [grc_pkg::M_TDATA_W-1:0]   m_tdata,  // min_x[2:0], min_y[5:3],
                                                      // max_x[8:6], max_y[11:9]
    output logic                            m_tuser,  // set_empty
    output logic                            m_tlast   // last_rect
);

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_FIND  = 5'b00010,
        ST_GROW  = 5'b00100,
        ST_PUSH  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // scan position and current rectangle
    logic [grc_pkg::ROW_W-1:0]     ptr_y_reg, ptr_y_next;
    logic [grc_pkg::ROW_CNT_W-1:0] cy_reg, cy_next;
    logic [grc_pkg::COL_W-1:0]     sx_reg, sx_next;
    logic [grc_pkg::COL_W-1:0]     ex_reg, ex_next;
    logic [grc_pkg::ROW_W-1:0]     sy_reg, sy_next;
    logic [grc_pkg::ROW_W-1:0]     ey_reg, ey_next;
    grc_pkg::row_t                 mask_reg, mask_next;

    // held rectangle, released once the next one is known (or at the end)
    logic                          pend_valid_reg, pend_valid_next;
    logic [4*grc_pkg::CELL_W-1:0]  pend_reg, pend_next;
    logic [grc_pkg::CNT_W-1:0]     count_reg, count_next;

    // output register
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [grc_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg, m_tuser_next;
    logic                          m_tlast_reg, m_tlast_next;

    grc_pkg::wr_req_t              wr;
    logic [grc_pkg::ROW_W-1:0]     rd_addr;
    grc_pkg::row_t                 rd_data;
    logic                          occ_any;
    grc_pkg::scan_res_t            scan;

    logic [grc_pkg::CELL_W-1:0]    in_x;
    logic [grc_pkg::CELL_W-1:0]    in_y;
    logic                          in_grid;
    logic                          out_free;

    grc_bitmap u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .occ_any (occ_any)
    );

    grc_row_unit u_row_unit (
        .row_data  (rd_data),
        .span_mask (mask_reg),
        .res       (scan)
    );

    assign in_x     = s_tdata[grc_pkg::CELL_W-1:0];
    assign in_y     = s_tdata[2*grc_pkg::CELL_W-1:grc_pkg::CELL_W];
    // cells outside the window are dropped
    assign in_grid  = (int'(in_x) < grc_pkg::GRID_COLUMNS) &&
                      (int'(in_y) < grc_pkg::GRID_ROWS);
    assign out_free = !m_tvalid_reg || m_tready;

    // start search reads the scan row, growth reads the candidate row
    assign rd_addr  = (state_reg == ST_FIND) ? ptr_y_reg : cy_reg[grc_pkg::ROW_W-1:0];

    always_comb begin
        state_next      = state_reg;
        ptr_y_next      = ptr_y_reg;
        cy_next         = cy_reg;
        sx_next         = sx_reg;
        ex_next         = ex_reg;
        sy_next         = sy_reg;
        ey_next         = ey_reg;
        mask_next       = mask_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        count_next      = count_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;
        wr              = '0;
        s_tready        = 1'b0;

        // result taken downstream
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser && in_grid) begin
                        wr.en   = 1'b1;
                        wr.set  = 1'b1;
                        wr.addr = grc_pkg::ROW_W'(in_y);
                        wr.mask = grc_pkg::row_t'(1) << grc_pkg::COL_W'(in_x);
                    end
                    if (s_tlast) begin
                        ptr_y_next = '0;
                        state_next = ST_FIND;
                    end
                end
            end

            ST_FIND: begin
                if (!occ_any) begin
                    state_next = ST_FLUSH;
                end else if (!scan.nonzero) begin
                    // a later row still holds cells
                    ptr_y_next = ptr_y_reg + grc_pkg::ROW_W'(1);
                end else begin
                    sx_next   = scan.first_x;
                    ex_next   = scan.last_x;
                    sy_next   = ptr_y_reg;
                    mask_next = scan.run_mask;
                    cy_next   = grc_pkg::ROW_CNT_W'(ptr_y_reg) + grc_pkg::ROW_CNT_W'(1);
                    wr.en     = 1'b1;
                    wr.set    = 1'b0;
                    wr.addr   = ptr_y_reg;
                    wr.mask   = scan.run_mask;
                    state_next = ST_GROW;
                end
            end

            ST_GROW: begin
                if (cy_reg != grc_pkg::ROW_CNT_W'(grc_pkg::GRID_ROWS) && scan.span_full) begin
                    wr.en   = 1'b1;
                    wr.set  = 1'b0;
                    wr.addr = cy_reg[grc_pkg::ROW_W-1:0];
                    wr.mask = mask_reg;
                    cy_next = cy_reg + grc_pkg::ROW_CNT_W'(1);
                end else begin
                    ey_next    = grc_pkg::ROW_W'(cy_reg - grc_pkg::ROW_CNT_W'(1));
                    state_next = ST_PUSH;
                end
            end

            ST_PUSH: begin
                if (count_reg < grc_pkg::CNT_W'(grc_pkg::MAX_RESULTS)) begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = grc_pkg::M_TDATA_W'(pend_reg);
                            m_tuser_next  = 1'b0;
                            m_tlast_next  = 1'b0;
                        end
                        pend_next       = {grc_pkg::CELL_W'(ey_reg), grc_pkg::CELL_W'(ex_reg),
                                           grc_pkg::CELL_W'(sy_reg), grc_pkg::CELL_W'(sx_reg)};
                        pend_valid_next = 1'b1;
                        count_next      = count_reg + grc_pkg::CNT_W'(1);
                        state_next      = ST_FIND;
                    end
                end else begin
                    // past the result limit: already cleared, not reported
                    state_next = ST_FIND;
                end
            end

            ST_FLUSH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    if (pend_valid_reg) begin
                        m_tdata_next = grc_pkg::M_TDATA_W'(pend_reg);
                        m_tuser_next = 1'b0;
                    end else begin
                        m_tdata_next = '0;
                        m_tuser_next = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    state_next      = ST_LOAD;
                end
            end

            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            ptr_y_reg      <= '0;
            cy_reg         <= '0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            m_tvalid_reg   <= m_tvalid_next;
            ptr_y_reg      <= ptr_y_next;
            cy_reg         <= cy_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sx_reg      <= sx_next;
        ex_reg      <= ex_next;
        sy_reg      <= sy_next;
        ey_reg      <= ey_next;
        mask_reg    <= mask_next;
        pend_reg    <= pend_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // the bitmap is fully cleared before the final result is queued
    a_clear_at_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> !occ_any)
        else $error("bitmap not clear at end of merge");

    // an empty-set result is the only result of its merge and has zero corners
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("empty-set result malformed");

    // no rectangle is held over into the next load
    a_no_pending_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> !pend_valid_reg)
        else $error("rectangle left pending after merge");

    // a grown rectangle has ordered corners
    a_ordered_corners: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH) |-> (ex_reg >= sx_reg && ey_reg >= sy_reg))
        else $error("rectangle corners out of order");
`endif

endmodule

@@ test/tb_greedy_rectangle_cover.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_rectangle_cover: self-checking bench for the greedy rectangle cover
// streams windows of cells in, predicts the raster-order rectangle cover of
// each window and checks every rectangle request against the prediction
// ----------------------------------------------------------------------------
module tb_greedy_rectangle_cover;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 300;    // random requests with idling
    localparam int CALM_ITEMS = 40;       // random requests at full rate, no idling

    // one predicted rectangle request
    typedef struct packed {
        logic [grc_pkg::CELL_W-1:0] min_x;
        logic [grc_pkg::CELL_W-1:0] min_y;
        logic [grc_pkg::CELL_W-1:0] max_x;
        logic [grc_pkg::CELL_W-1:0] max_y;
        logic                       last_rect;
        logic                       set_empty;
    } rect_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [grc_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = 1'b0;
    logic                          s_tlast = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [grc_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;

    grc_pkg::row_t occ_rows [grc_pkg::GRID_ROWS];  // predicted occupancy bitmap
    rect_t pending_rects [$];     // rectangles still owed by the block
    int    mismatches = 0;
    int    cycle_count = 0;
    int    items_sent = 0;        // accepted requests
    int    hold_left = 0;         // long receiver hold-off, counted down by the receiver
    bit    idle_on = 1'b1;        // random idling on both sides

    greedy_rectangle_cover dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // predictor: load one accepted cell request and, on the window end,
    // cover the bitmap with rectangles in raster order
    task automatic predict_cover(input logic [grc_pkg::CELL_W-1:0] x,
                                 input logic [grc_pkg::CELL_W-1:0] y,
                                 input logic present, input logic last);
        rect_t         found [$];
        rect_t         r;
        int            sx, sy, w, h, cy, cx, emitted;
        bit            hit;
        grc_pkg::row_t span;

        emitted = 0;
        if (present && x < grc_pkg::GRID_COLUMNS && y < grc_pkg::GRID_ROWS)
            occ_rows[y][x] = 1'b1;
        if (!last)
            return;

        forever begin
            // raster search for the start cell
            hit = 1'b0;
            sx = 0;
            sy = 0;
            for (cy = 0; cy < grc_pkg::GRID_ROWS && !hit; cy++)
                for (cx = 0; cx < grc_pkg::GRID_COLUMNS && !hit; cx++)
                    if (occ_rows[cy][cx]) begin
                        hit = 1'b1;
                        sx = cx;
                        sy = cy;
                    end
            if (!hit)
                break;
            // grow right, then up while the full span remains
            w = 1;
            while (sx + w < grc_pkg::GRID_COLUMNS && occ_rows[sy][sx + w])
                w++;
            span = grc_pkg::row_t'(((64'd1 << w) - 64'd1) << sx);
            h = 1;
            while (sy + h < grc_pkg::GRID_ROWS && (occ_rows[sy + h] & span) == span)
                h++;
            for (cy = sy; cy < sy + h; cy++)
                occ_rows[cy] &= ~span;
            if (emitted < grc_pkg::MAX_RESULTS) begin
                r.min_x = grc_pkg::CELL_W'(sx);
                r.min_y = grc_pkg::CELL_W'(sy);
                r.max_x = grc_pkg::CELL_W'(sx + w - 1);
                r.max_y = grc_pkg::CELL_W'(sy + h - 1);
                r.last_rect = 1'b0;
                r.set_empty = 1'b0;
                found = {found, r};
                emitted++;
            end
        end

        if (found.size() == 0) begin
            r = '0;
            r.last_rect = 1'b1;
            r.set_empty = 1'b1;
            found = {found, r};
        end else begin
            found[found.size() - 1].last_rect = 1'b1;
        end
        foreach (found[i])
            pending_rects = {pending_rects, found[i]};
    endtask

    // offer one cell request, wait for acceptance, then maybe idle
    task automatic send_cell(input logic [grc_pkg::CELL_W-1:0] x,
                             input logic [grc_pkg::CELL_W-1:0] y,
                             input logic present, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(grc_pkg::S_TDATA_W - 2 * grc_pkg::CELL_W){1'b0}}, y, x};
        s_tuser  <= present;
        s_tlast  <= last;
        do
            @(posedge aclk);
        while (!s_tready);
        predict_cover(x, y, present, last);
        items_sent++;
        // sender gap, dropped in the same step as the acceptance
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // receiver: check each accepted rectangle, then pick the next ready level
    initial begin : rect_receiver
        rect_t want;
        int    stall_left;

        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready) begin
                if (pending_rects.size() == 0) begin
                    report_mismatch($sformatf("rectangle with none expected, tdata %h", m_tdata));
                end else begin
                    want = pending_rects.pop_front();
                    if (m_tdata[2:0] !== want.min_x)
                        report_mismatch($sformatf("min_x %0d, want %0d", m_tdata[2:0], want.min_x));
                    if (m_tdata[5:3] !== want.min_y)
                        report_mismatch($sformatf("min_y %0d, want %0d", m_tdata[5:3], want.min_y));
                    if (m_tdata[8:6] !== want.max_x)
                        report_mismatch($sformatf("max_x %0d, want %0d", m_tdata[8:6], want.max_x));
                    if (m_tdata[11:9] !== want.max_y)
                        report_mismatch($sformatf("max_y %0d, want %0d", m_tdata[11:9],
                                                  want.max_y));
                    if (m_tlast !== want.last_rect)
                        report_mismatch($sformatf("last_rect %b, want %b", m_tlast,
                                                  want.last_rect));
                    if (m_tuser !== want.set_empty)
                        report_mismatch($sformatf("set_empty %b, want %b", m_tuser,
                                                  want.set_empty));
                end
            end
            // long hold-off first, then random stall bursts
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // send a list of cells (x + 8 * y) as one window; end_style 0 ends on the
    // last cell, 1 adds a bare end marker, 2 leaves the window open
    task automatic send_window(input int cells [$], input int end_style);
        int i, c;

        for (i = 0; i < cells.size(); i++) begin
            // ignored filler between cells
            if ($urandom_range(0, 9) == 0)
                send_cell(grc_pkg::CELL_W'($urandom), grc_pkg::CELL_W'($urandom), 1'b0, 1'b0);
            c = cells[i];
            send_cell(grc_pkg::CELL_W'(c % 8), grc_pkg::CELL_W'(c / 8), 1'b1,
                      (end_style == 0 && i == cells.size() - 1));
        end
        if (end_style == 1 || (end_style == 0 && cells.size() == 0))
            send_cell(grc_pkg::CELL_W'($urandom), grc_pkg::CELL_W'($urandom), 1'b0, 1'b1);
    endtask

    task automatic shuffle_cells(ref int cells [$]);
        int i, j, t;

        for (i = cells.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = cells[i];
            cells[i] = cells[j];
            cells[j] = t;
        end
    endtask

    // one random window: sparse, dense, union of blocks, checkerboard, full
    // grid, empty, or a broken window that spills into the next one
    task automatic send_random_window();
        int cells [$];
        bit fill [64];
        int mode, n, i, k, x0, y0, x1, y1, cx, cy, fill_pct, phase, end_style;

        mode = $urandom_range(0, 99);
        end_style = $urandom_range(0, 1);
        for (i = 0; i < 64; i++)
            fill[i] = 1'b0;
        if (mode < 30) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                cells = {cells, int'($urandom_range(0, 63))};
        end else if (mode < 55) begin
            fill_pct = $urandom_range(20, 90);
            for (i = 0; i < 64; i++)
                if ($urandom_range(0, 99) < fill_pct)
                    cells = {cells, i};
        end else if (mode < 75) begin
            k = $urandom_range(1, 4);
            for (i = 0; i < k; i++) begin
                x0 = $urandom_range(0, 7);
                y0 = $urandom_range(0, 7);
                x1 = $urandom_range(x0, 7);
                y1 = $urandom_range(y0, 7);
                for (cy = y0; cy <= y1; cy++)
                    for (cx = x0; cx <= x1; cx++)
                        fill[cx + 8 * cy] = 1'b1;
            end
            for (i = 0; i < 64; i++)
                if (fill[i])
                    cells = {cells, i};
        end else if (mode < 82) begin
            // most rectangles a window can give
            phase = $urandom_range(0, 1);
            for (i = 0; i < 64; i++)
                if (((i % 8) + (i / 8)) % 2 == phase)
                    cells = {cells, i};
        end else if (mode < 86) begin
            for (i = 0; i < 64; i++)
                cells = {cells, i};
        end else if (mode < 91) begin
            end_style = 1;
        end else begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
                cells = {cells, int'($urandom_range(0, 63))};
            end_style = 2;
        end
        shuffle_cells(cells);
        // repeated cells
        if (cells.size() > 0 && $urandom_range(0, 9) == 0)
            cells = {cells, cells[$urandom_range(0, cells.size() - 1)]};
        send_window(cells, end_style);
    endtask

    task automatic test_corner_cases();
        int cells [$];

        // empty window: bare end marker
        send_cell(3'd0, 3'd0, 1'b0, 1'b1);
        // far corner carried on the end request itself
        send_cell(3'd7, 3'd7, 1'b1, 1'b1);
        // repeated cell merges into one rectangle
        send_cell(3'd3, 3'd2, 1'b1, 1'b0);
        send_cell(3'd3, 3'd2, 1'b1, 1'b0);
        send_cell(3'd3, 3'd2, 1'b1, 1'b1);
        // bare request without end is ignored, even with cell bits set
        send_cell(3'd7, 3'd7, 1'b0, 1'b0);
        send_cell(3'd0, 3'd0, 1'b1, 1'b0);
        send_cell(3'd7, 3'd0, 1'b1, 1'b0);
        send_cell(3'd5, 3'd5, 1'b0, 1'b1);
        // full column, grows upward to the top row
        cells = {5, 13, 21, 29, 37, 45, 53, 61};
        send_window(cells, 0);
        // l-shape: wide bottom row, narrow row above stays separate
        cells = {0, 1, 8};
        send_window(cells, 0);
    endtask

    // receiver holds off while the sender keeps offering windows
    task automatic test_backpressure();
        int cells [$];
        int w;

        hold_left = 400;
        for (w = 0; w < 4; w++) begin
            cells = {0, 2, 9, 20, 63};
            shuffle_cells(cells);
            send_window(cells, 0);
        end
    endtask

    task automatic test_random_windows(input int count);
        int stop_at;

        stop_at = items_sent + count;
        while (items_sent < stop_at)
            send_random_window();
    endtask

    initial begin : stimulus
        foreach (occ_rows[i])
            occ_rows[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_cases();
        test_backpressure();
        test_random_windows(RANDOM_ITEMS);
        // last stretch at full rate on both sides, closed with an end marker
        idle_on = 1'b0;
        test_random_windows(CALM_ITEMS);
        send_cell(3'd0, 3'd0, 1'b0, 1'b1);
        s_tvalid <= 1'b0;

        // drain, then watch for stray rectangles
        while (pending_rects.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
